### rtl/omcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// omcm_pkg
// Shared types and constants of the ordered midpoint circle mask: state
// encoding, controller/datapath command and status words, field widths.
// ----------------------------------------------------------------------------
package omcm_pkg;

    // Field widths
    localparam int COORD_W = 8;   // stored octant coordinate
    localparam int IDX_W   = 11;  // entry index
    localparam int CNT_W   = 11;  // ring count
    localparam int PT_W    = 9;   // signed point offset
    localparam int ERR_W   = 12;  // recurrence error and gradient terms
    localparam int WORD_W  = 2 * COORD_W;
    localparam int QTR_W   = CNT_W - 2;     // quarter ring count
    localparam int MSQ_W   = 2 * COORD_W + 2;

    // Radius saturation limit
    localparam int MAX_RADIUS = 255;

    // Diagonal corners follow the ring entries
    localparam int NUM_CORNERS = 4;

    // Operation codes carried in the input tuser
    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef logic signed [ERR_W-1:0] t_err;
    typedef logic signed [PT_W-1:0]  t_point;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_BUILD_OUT,
        ST_FETCH_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic start_build;  // load recurrence start values
        logic start_fetch;  // decode index, read octant store
        logic step;         // advance arc and diagonal search
        logic load_out;     // load output register
        logic load_build;   // output word is a build result, commit build
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic arc_done;
        logic diag_done;
    } t_dp_sts;

endpackage

`default_nettype wire

### rtl/omcm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// omcm_ctrl
// Sequencer: accepts one word at a time, runs a build until the arc and the
// diagonal search are both done, and owns the output word valid flag.
// ----------------------------------------------------------------------------
module omcm_ctrl
    import omcm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_op,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output logic         o_in_ready,
    output logic         o_out_valid,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;
    logic   w_accept;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;

    // State and output slot registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_op == OP_BUILD) begin
                        o_cmd.start_build = 1'b1;
                        n_state           = ST_BUILD;
                    end else begin
                        o_cmd.start_fetch = 1'b1;
                        n_state           = ST_FETCH_OUT;
                    end
                end
            end
            ST_BUILD: begin
                o_cmd.step = 1'b1;
                if (i_sts.arc_done && i_sts.diag_done) begin
                    n_state = ST_BUILD_OUT;
                end
            end
            ST_BUILD_OUT: begin
                if (w_out_free) begin
                    o_cmd.load_out   = 1'b1;
                    o_cmd.load_build = 1'b1;
                    n_out_valid      = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            ST_FETCH_OUT: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/omcm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// omcm_datapath
// Radius register, midpoint recurrence, diagonal reach search, octant store,
// index decode with quadrant rotation, and the output word register.
// ----------------------------------------------------------------------------
module omcm_datapath
    import omcm_pkg::*;
#(
    parameter int OCTANT_DEPTH = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [COORD_W-1:0] i_cfg_wr_data,
    input  wire logic [IDX_W-1:0]   i_entry_index,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_sts                 o_sts,
    output t_point                  o_point_x,
    output t_point                  o_point_y,
    output logic [CNT_W-1:0]        o_ring_count,
    output logic                    o_entry_valid
);

    localparam int AW = (OCTANT_DEPTH > 1) ? $clog2(OCTANT_DEPTH) : 1;

    // Configuration and committed build state
    logic [COORD_W-1:0] r_radius;
    logic               r_built;
    logic [COORD_W-1:0] r_steps;
    logic [CNT_W-1:0]   r_total;
    logic [COORD_W-1:0] r_reach;

    // Build working registers
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    t_err               r_err;
    t_err               r_gx;
    t_err               r_gy;
    logic [COORD_W-1:0] r_n;
    logic [CNT_W-1:0]   r_count;
    logic [COORD_W-1:0] r_m;
    logic [MSQ_W-1:0]   r_msq2;
    logic [WORD_W-1:0]  r_r2;

    // Fetch decode registers
    logic               r_hit_corner;
    logic [1:0]         r_corner_c;
    logic               r_hit_ring;
    logic [1:0]         r_quad;
    logic               r_j_zero;
    logic               r_j_le_n;
    logic               r_t_ok;
    logic [WORD_W-1:0]  r_rd_word;

    // Output word
    t_point             r_px;
    t_point             r_py;
    logic [CNT_W-1:0]   r_ring;
    logic               r_ev;

    logic [WORD_W-1:0]  r_octant_mem [OCTANT_DEPTH];

    logic [COORD_W-1:0] w_eff;

    // Effective radius after saturation
    assign w_eff = (32'(r_radius) > MAX_RADIUS) ? COORD_W'(MAX_RADIUS) : r_radius;

    // ---------------- recurrence step ----------------
    logic               w_err_ge;
    t_err               w_gy1;
    t_err               w_err1;
    t_err               w_gx1;
    logic [COORD_W-1:0] w_x1;
    logic [COORD_W-1:0] w_y1;
    logic               w_arc_run;
    logic               w_diag_run;
    logic               w_wr_en;

    assign w_err_ge   = !r_err[ERR_W-1];
    assign w_gy1      = w_err_ge ? (r_gy + t_err'(2)) : r_gy;
    assign w_err1     = w_err_ge ? (r_err + w_gy1) : r_err;
    assign w_gx1      = r_gx + t_err'(2);
    assign w_x1       = r_x + COORD_W'(1);
    assign w_y1       = w_err_ge ? (r_y - COORD_W'(1)) : r_y;
    assign w_arc_run  = r_x < r_y;
    assign w_diag_run = r_msq2 < MSQ_W'(r_r2);
    assign w_wr_en    = i_cmd.step && w_arc_run && (32'(r_n) < OCTANT_DEPTH);

    assign o_sts.arc_done  = !w_arc_run;
    assign o_sts.diag_done = !w_diag_run;

    // Arc and diagonal search, one step per cycle each
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_build) begin
            r_x     <= '0;
            r_y     <= w_eff;
            r_err   <= t_err'(1) - t_err'({1'b0, w_eff});
            r_gx    <= t_err'(1);
            r_gy    <= -t_err'({w_eff, 1'b0});
            r_n     <= '0;
            r_count <= CNT_W'(NUM_CORNERS);
            r_m     <= '0;
            r_msq2  <= '0;
            r_r2    <= WORD_W'(w_eff) * WORD_W'(w_eff);
        end else if (i_cmd.step) begin
            if (w_arc_run) begin
                r_x     <= w_x1;
                r_y     <= w_y1;
                r_gy    <= w_gy1;
                r_gx    <= w_gx1;
                r_err   <= w_err1 + w_gx1;
                r_n     <= r_n + COORD_W'(1);
                r_count <= r_count + ((w_x1 != w_y1) ? CNT_W'(8) : CNT_W'(4));
            end
            if (w_diag_run) begin
                r_m    <= r_m + COORD_W'(1);
                r_msq2 <= r_msq2 + MSQ_W'({r_m, 2'b00}) + MSQ_W'(2);
            end
        end
    end

    // Octant store write
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_octant_mem[AW'(r_n)] <= {w_x1, w_y1};
        end
    end

    // ---------------- fetch decode ----------------
    logic [IDX_W-1:0]   w_c_diff;
    logic               w_corner;
    logic               w_ring;
    logic [QTR_W-1:0]   w_q4;
    logic [CNT_W-1:0]   w_q1e;
    logic [CNT_W-1:0]   w_q2e;
    logic [CNT_W-1:0]   w_q3e;
    logic [1:0]         w_quad;
    logic [IDX_W-1:0]   w_j_full;
    logic [QTR_W-1:0]   w_j;
    logic               w_j_le_n;
    logic [QTR_W-1:0]   w_t;
    logic               w_t_ok;
    logic [AW-1:0]      w_rd_addr;

    assign w_c_diff = i_entry_index - r_total;
    assign w_corner = (i_entry_index >= r_total) && (32'(w_c_diff) < NUM_CORNERS);
    assign w_ring   = i_entry_index < r_total;
    assign w_q4     = r_total[CNT_W-1:2];
    assign w_q1e    = CNT_W'(w_q4);
    assign w_q2e    = CNT_W'({w_q4, 1'b0});
    assign w_q3e    = w_q1e + w_q2e;

    // Quadrant by comparison against multiples of the quarter count
    always_comb begin
        if (i_entry_index >= w_q3e) begin
            w_quad   = 2'd3;
            w_j_full = i_entry_index - w_q3e;
        end else if (i_entry_index >= w_q2e) begin
            w_quad   = 2'd2;
            w_j_full = i_entry_index - w_q2e;
        end else if (i_entry_index >= w_q1e) begin
            w_quad   = 2'd1;
            w_j_full = i_entry_index - w_q1e;
        end else begin
            w_quad   = 2'd0;
            w_j_full = i_entry_index;
        end
    end

    assign w_j       = w_j_full[QTR_W-1:0];
    assign w_j_le_n  = w_j <= QTR_W'(r_steps);
    assign w_t       = w_j_le_n ? w_j : (w_q4 - w_j);
    assign w_t_ok    = (w_t != '0) && (32'(w_t) <= OCTANT_DEPTH);
    assign w_rd_addr = AW'(w_t - QTR_W'(1));

    // Latch decode and read the store
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_fetch) begin
            r_hit_corner <= r_built && w_corner;
            r_corner_c   <= w_c_diff[1:0];
            r_hit_ring   <= r_built && w_ring;
            r_quad       <= w_quad;
            r_j_zero     <= (w_j == '0);
            r_j_le_n     <= w_j_le_n;
            r_t_ok       <= w_t_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_fetch && w_t_ok) begin
            r_rd_word <= r_octant_mem[w_rd_addr];
        end
    end

    // ---------------- point forming ----------------
    logic [WORD_W-1:0]  w_word;
    t_point             w_lo;
    t_point             w_hi;
    t_point             w_a;
    t_point             w_b;
    t_point             w_rx;
    t_point             w_ry;
    t_point             w_mpos;
    t_point             w_cx;
    t_point             w_cy;

    assign w_word = r_t_ok ? r_rd_word : '0;
    assign w_lo   = t_point'({1'b0, w_word[COORD_W-1:0]});
    assign w_hi   = t_point'({1'b0, w_word[WORD_W-1:COORD_W]});
    assign w_mpos = t_point'({1'b0, r_reach});

    // First quadrant point: axis point, octant, or mirrored octant
    always_comb begin
        if (r_j_zero) begin
            w_a = t_point'({1'b0, w_eff});
            w_b = '0;
        end else if (r_j_le_n) begin
            w_a = w_lo;
            w_b = -w_hi;
        end else begin
            w_a = w_hi;
            w_b = -w_lo;
        end
    end

    // Quarter turn (a,b) -> (b,-a), applied quad times
    always_comb begin
        case (r_quad)
            2'd0: begin
                w_rx = w_a;
                w_ry = w_b;
            end
            2'd1: begin
                w_rx = w_b;
                w_ry = -w_a;
            end
            2'd2: begin
                w_rx = -w_a;
                w_ry = -w_b;
            end
            2'd3: begin
                w_rx = -w_b;
                w_ry = w_a;
            end
            default: begin
                w_rx = w_a;
                w_ry = w_b;
            end
        endcase
    end

    // Diagonal corners in order (m,-m), (-m,-m), (-m,m), (m,m)
    assign w_cx = (r_corner_c == 2'd1 || r_corner_c == 2'd2) ? -w_mpos : w_mpos;
    assign w_cy = (r_corner_c == 2'd0 || r_corner_c == 2'd1) ? -w_mpos : w_mpos;

    // Output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (i_cmd.load_build) begin
                r_px   <= '0;
                r_py   <= '0;
                r_ring <= r_count;
                r_ev   <= 1'b0;
            end else begin
                r_ring <= r_built ? r_total : '0;
                if (r_hit_corner) begin
                    r_px <= w_cx;
                    r_py <= w_cy;
                    r_ev <= 1'b1;
                end else if (r_hit_ring) begin
                    r_px <= w_rx;
                    r_py <= w_ry;
                    r_ev <= 1'b1;
                end else begin
                    r_px <= '0;
                    r_py <= '0;
                    r_ev <= 1'b0;
                end
            end
        end
    end

    // Radius register and committed build results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= COORD_W'(1);
            r_built  <= 1'b0;
            r_steps  <= '0;
            r_total  <= '0;
            r_reach  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_radius <= i_cfg_wr_data;
                r_built  <= 1'b0;
            end else if (i_cmd.load_out && i_cmd.load_build) begin
                r_steps <= r_n;
                r_total <= r_count;
                r_reach <= r_m;
                r_built <= 1'b1;
            end
        end
    end

    assign o_point_x     = r_px;
    assign o_point_y     = r_py;
    assign o_ring_count  = r_ring;
    assign o_entry_valid = r_ev;

endmodule

`default_nettype wire

### rtl/ordered_midpoint_circle_mask_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_midpoint_circle_mask_top
// Raster circle mask: builds the first octant of a midpoint circle for the
// configured radius and serves ring points and diagonal corners by index.
// ----------------------------------------------------------------------------
// A build word (tuser 0) runs the midpoint recurrence one step per cycle and,
// alongside it, the diagonal reach search one step per cycle, and returns the
// new ring count. A fetch word (tuser 1) has its index decoded and the octant
// store read in the accept cycle; the point is then rotated into its quadrant
// and loaded into the output register once that register is free. One word is
// in work at a time; the output register lets the next word be accepted
// while a result waits on m_axis_tready. Writing the radius invalidates the
// stored mask until the next build. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module ordered_midpoint_circle_mask_top
    import omcm_pkg::*;
#(
    parameter int OCTANT_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Radius register
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    // Request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [10:0] entry_index
    input  wire logic        s_axis_tuser,   // [0] operation
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [8:0] point_x, [17:9] point_y,
                                             // [28:18] ring_count
    output logic             m_axis_tuser    // [0] entry_valid
);

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    t_point           w_point_x;
    t_point           w_point_y;
    logic [CNT_W-1:0] w_ring_count;
    logic             w_entry_valid;

    // Sequencer
    omcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_op     (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    // Datapath
    omcm_datapath #(
        .OCTANT_DEPTH (OCTANT_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_entry_index (s_axis_tdata[IDX_W-1:0]),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_point_x     (w_point_x),
        .o_point_y     (w_point_y),
        .o_ring_count  (w_ring_count),
        .o_entry_valid (w_entry_valid)
    );

    // Result word packing
    assign m_axis_tdata = {3'b000, w_ring_count, w_point_y, w_point_x};
    assign m_axis_tuser = w_entry_valid;

endmodule

`default_nettype wire

### rtl/omcm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// omcm_checker
// Port-level checks of the circle mask, bound to the top level.
// ----------------------------------------------------------------------------
module omcm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // One word in work at a time: no accept right after an accept
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("word accepted while previous word in work");

    // Ring count is always a multiple of four
    a_ring_mult4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[19:18] == 2'b00)
        else $error("ring count not a multiple of four");

    // A valid entry implies a built, nonempty ring
    a_valid_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[28:18] != 11'd0)
        else $error("valid entry with zero ring count");

endmodule

bind ordered_midpoint_circle_mask_top omcm_checker u_omcm_checker (.*);

`default_nettype wire

### test/tb_ordered_midpoint_circle_mask_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_midpoint_circle_mask_top
// Self-checking bench for the circle mask. A short table of build and fetch
// words covers the reset state, radius 0, 1 and 255, the corners and
// out-of-range indices. Random build/fetch sequences follow over many radius
// settings. Every result word is checked field by field against its typed row
// or a midpoint circle predictor, under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_ordered_midpoint_circle_mask_top;
    import omcm_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int OCT_DEPTH    = 256;
    localparam int RANDOM_ITEMS = 640;
    localparam int TAIL_CYCLES  = 200;  // longer than the slowest build
    localparam int MAX_INDEX    = (1 << IDX_W) - 1;

    typedef struct {
        t_point           px;
        t_point           py;
        logic [CNT_W-1:0] ring;
        logic             valid;
    } t_mask_entry;

    typedef enum logic { ROW_RADIUS, ROW_WORD } t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [7:0]        radius;
        logic              op;
        logic [IDX_W-1:0]  idx;
        logic              typed;
        t_mask_entry       want;
    } t_dir_row;

    // DUT signals
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    // Predictor state
    logic [15:0] oct_mem [OCT_DEPTH];
    int          oct_steps;
    int          ring_total;
    int          diag_reach;
    bit          mask_ready;
    int          radius_q;

    // Bench bookkeeping
    t_mask_entry pending_points[$];
    t_mask_entry got_entry;
    t_mask_entry want_entry;
    t_mask_entry no_entry;
    t_dir_row    dir_rows[$];
    int          src_idle_pct;
    int          sink_idle_pct;
    int          fail_count;
    int          cycle_count;

    ordered_midpoint_circle_mask_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Run-time guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Midpoint recurrence over the first octant, plus the diagonal reach
    function automatic void build_octant_model();
        int r, err, gx, gy, x, y, n, cnt, m;
        r = radius_q & 8'hFF;
        if (r > MAX_RADIUS) r = MAX_RADIUS;
        err = 1 - r;
        gx = 1;
        gy = -2 * r;
        x = 0;
        y = r;
        n = 0;
        cnt = 4;
        m = 0;
        while (x < y) begin
            if (err >= 0) begin
                y = y - 1;
                gy = gy + 2;
                err = err + gy;
            end
            x = x + 1;
            gx = gx + 2;
            err = err + gx;
            cnt = cnt + ((x != y) ? 8 : 4);
            if (n < OCT_DEPTH) oct_mem[n] = {x[7:0], y[7:0]};
            n = n + 1;
        end
        while (2 * m * m < r * r) m = m + 1;
        oct_steps  = n & 8'hFF;
        ring_total = cnt & 11'h7FF;
        diag_reach = m & 8'hFF;
        mask_ready = 1'b1;
    endfunction

    function automatic logic [15:0] octant_word(int t);
        if (t == 0 || t > OCT_DEPTH) return 16'd0;
        return oct_mem[t-1];
    endfunction

    // Expected result word for one request word; a build updates the state
    function automatic t_mask_entry predict_mask_entry(logic op, logic [IDX_W-1:0] idx);
        t_mask_entry e;
        int s, c, q4, quad, j, a, b, t, r;
        logic [15:0] w;
        e.px = '0;
        e.py = '0;
        e.valid = 1'b0;
        if (op == OP_BUILD) begin
            build_octant_model();
        end else if (mask_ready) begin
            s = ring_total;
            if (idx >= s && idx < s + NUM_CORNERS) begin
                // diagonal corners in order (m,-m), (-m,-m), (-m,m), (m,m)
                c = idx - s;
                a = (c == 1 || c == 2) ? -diag_reach : diag_reach;
                b = (c == 0 || c == 1) ? -diag_reach : diag_reach;
                e.px = a[PT_W-1:0];
                e.py = b[PT_W-1:0];
                e.valid = 1'b1;
            end else if (idx < s) begin
                q4 = s / 4;
                quad = idx / q4;
                j = idx % q4;
                r = radius_q & 8'hFF;
                if (r > MAX_RADIUS) r = MAX_RADIUS;
                if (j == 0) begin
                    a = r;
                    b = 0;
                end else if (j <= oct_steps) begin
                    w = octant_word(j);
                    a = int'(w[7:0]);
                    b = -int'(w[15:8]);
                end else begin
                    // mirrored half of the quadrant
                    w = octant_word(q4 - j);
                    a = int'(w[15:8]);
                    b = -int'(w[7:0]);
                end
                for (int k = 0; k < (quad & 3); k++) begin
                    t = a;
                    a = b;
                    b = -t;
                end
                e.px = a[PT_W-1:0];
                e.py = b[PT_W-1:0];
                e.valid = 1'b1;
            end
        end
        e.ring = mask_ready ? ring_total[CNT_W-1:0] : '0;
        return e;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(input t_dir_row row);
        dir_rows = {dir_rows, row};
    endfunction

    // Result side: random stalls and field-by-field check
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_entry.px    = m_axis_tdata[8:0];
            got_entry.py    = m_axis_tdata[17:9];
            got_entry.ring  = m_axis_tdata[28:18];
            got_entry.valid = m_axis_tuser;
            if (pending_points.size() == 0) begin
                $error("result word with no expected entry waiting");
                fail_count++;
            end else begin
                want_entry = pending_points.pop_front();
                if (got_entry.px !== want_entry.px) begin
                    $error("point_x expected %0d actual %0d", want_entry.px, got_entry.px);
                    fail_count++;
                end
                if (got_entry.py !== want_entry.py) begin
                    $error("point_y expected %0d actual %0d", want_entry.py, got_entry.py);
                    fail_count++;
                end
                if (got_entry.ring !== want_entry.ring) begin
                    $error("ring_count expected %0d actual %0d",
                           want_entry.ring, got_entry.ring);
                    fail_count++;
                end
                if (got_entry.valid !== want_entry.valid) begin
                    $error("entry_valid expected %0d actual %0d",
                           want_entry.valid, got_entry.valid);
                    fail_count++;
                end
            end
        end
    end

    // Present one request word and record its expected result on acceptance
    task automatic send_word(input logic op, input logic [IDX_W-1:0] idx,
                             input logic typed, input t_mask_entry typed_want);
        t_mask_entry e;
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < src_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(16-IDX_W){1'b0}}, idx};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        e = predict_mask_entry(op, idx);
        if (typed) e = typed_want;
        pending_points = {pending_points, e};
    endtask

    // Hold off the sender until every expected result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Radius write; the block is idle whenever this is called
    task automatic write_radius(input logic [7:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        radius_q   = int'(value);
        mask_ready = 1'b0;
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int         sent;
        int         nfetch;
        int         roll;
        int         top;
        logic [7:0] rad;
        logic [IDX_W-1:0] idx;

        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 8'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 16'd0;
        s_axis_tuser  <= OP_BUILD;
        m_axis_tready <= 1'b0;
        fail_count    = 0;
        cycle_count   = 0;
        src_idle_pct  = 36;
        sink_idle_pct = 66;
        no_entry      = '{9'sd0, 9'sd0, 11'd0, 1'b0};

        // predictor reset state
        for (int i = 0; i < OCT_DEPTH; i++) oct_mem[i] = 16'd0;
        oct_steps  = 0;
        ring_total = 0;
        diag_reach = 0;
        mask_ready = 1'b0;
        radius_q   = 1;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; typed rows carry their result, the rest are predicted
        // radius 1 from reset: fetch before build, then ring, corners, range
        add_row('{ROW_WORD, 8'd0, OP_FETCH, 11'd0, 1'b1,
                  '{9'sd0, 9'sd0, 11'd0, 1'b0}});
        add_row('{ROW_WORD, 8'd0, OP_BUILD, 11'd0, 1'b1,
                  '{9'sd0, 9'sd0, 11'd12, 1'b0}});
        add_row('{ROW_WORD, 8'd0, OP_FETCH, 11'd0, 1'b0, no_entry});
        add_row('{ROW_WORD, 8'd0, OP_FETCH, 11'd11, 1'b0, no_entry});
        add_row('{ROW_WORD, 8'd0, OP_FETCH, 11'd12, 1'b1,
                  '{9'sd1, -9'sd1, 11'd12, 1'b1}});
        add_row('{ROW_WORD, 8'd0, OP_FETCH, 11'd13, 1'b1,
                  '{-9'sd1, -9'sd1, 11'd12, 1'b1}});
        add_row('{ROW_WORD, 8'd0, OP_FETCH, 11'd15, 1'b1,
                  '{9'sd1, 9'sd1, 11'd12, 1'b1}});
        add_row('{ROW_WORD, 8'd0, OP_FETCH, 11'd16, 1'b1,
                  '{9'sd0, 9'sd0, 11'd12, 1'b0}});
        add_row('{ROW_WORD, 8'd0, OP_FETCH, 11'd2047, 1'b1,
                  '{9'sd0, 9'sd0, 11'd12, 1'b0}});
        // radius 0: stale mask dropped, ring of four points at the center
        add_row('{ROW_RADIUS, 8'd0, OP_BUILD, 11'd0, 1'b0, no_entry});
        add_row('{ROW_WORD, 8'd0, OP_FETCH, 11'd0, 1'b1,
                  '{9'sd0, 9'sd0, 11'd0, 1'b0}});
        add_row('{ROW_WORD, 8'd0, OP_BUILD, 11'd0, 1'b1,
                  '{9'sd0, 9'sd0, 11'd4, 1'b0}});
        add_row('{ROW_WORD, 8'd0, OP_FETCH, 11'd3, 1'b1,
                  '{9'sd0, 9'sd0, 11'd4, 1'b1}});
        add_row('{ROW_WORD, 8'd0, OP_FETCH, 11'd7, 1'b1,
                  '{9'sd0, 9'sd0, 11'd4, 1'b1}});
        add_row('{ROW_WORD, 8'd0, OP_FETCH, 11'd8, 1'b1,
                  '{9'sd0, 9'sd0, 11'd4, 1'b0}});
        // largest radius
        add_row('{ROW_RADIUS, 8'd255, OP_BUILD, 11'd0, 1'b0, no_entry});
        add_row('{ROW_WORD, 8'd0, OP_BUILD, 11'd0, 1'b0, no_entry});
        add_row('{ROW_WORD, 8'd0, OP_FETCH, 11'd0, 1'b0, no_entry});
        add_row('{ROW_WORD, 8'd0, OP_FETCH, 11'd1, 1'b0, no_entry});
        add_row('{ROW_WORD, 8'd0, OP_FETCH, 11'd500, 1'b0, no_entry});
        add_row('{ROW_WORD, 8'd0, OP_FETCH, 11'd1000, 1'b0, no_entry});
        add_row('{ROW_WORD, 8'd0, OP_FETCH, 11'd1455, 1'b0, no_entry});
        add_row('{ROW_WORD, 8'd0, OP_FETCH, 11'd2047, 1'b0, no_entry});
        // small radius with a mirrored half quadrant
        add_row('{ROW_RADIUS, 8'd2, OP_BUILD, 11'd0, 1'b0, no_entry});
        add_row('{ROW_WORD, 8'd0, OP_BUILD, 11'd0, 1'b0, no_entry});
        add_row('{ROW_WORD, 8'd0, OP_FETCH, 11'd5, 1'b0, no_entry});
        add_row('{ROW_WORD, 8'd0, OP_FETCH, 11'd19, 1'b0, no_entry});

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_RADIUS) begin
                drain_results();
                write_radius(dir_rows[i].radius);
            end else begin
                send_word(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].typed,
                          dir_rows[i].want);
            end
        end

        // Random sequences: new radius (usually), build, then mostly fetches
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 36;
                    sink_idle_pct = 66;
                end
                1: begin
                    src_idle_pct  = 66;
                    sink_idle_pct = 36;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS / 3) begin
                drain_results();
                roll = $urandom_range(0, 99);
                if (roll < 8) rad = 8'd0;
                else if (roll < 16) rad = 8'd255;
                else if (roll < 60) rad = 8'($urandom_range(1, 24));
                else rad = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 9) != 0) write_radius(rad);
                // occasional fetch before the build, often on an unbuilt mask
                if ($urandom_range(0, 4) == 0) begin
                    send_word(OP_FETCH, IDX_W'($urandom_range(0, MAX_INDEX)), 1'b0,
                              no_entry);
                    sent++;
                end
                send_word(OP_BUILD, IDX_W'($urandom_range(0, MAX_INDEX)), 1'b0, no_entry);
                sent++;
                nfetch = $urandom_range(5, 40);
                for (int k = 0; k < nfetch; k++) begin
                    roll = $urandom_range(0, 99);
                    top = ring_total + NUM_CORNERS - 1;
                    if (top > MAX_INDEX) top = MAX_INDEX;
                    if (roll < 85) begin
                        idx = IDX_W'($urandom_range(0, top));
                        send_word(OP_FETCH, idx, 1'b0, no_entry);
                    end else if (roll < 95) begin
                        send_word(OP_FETCH, IDX_W'($urandom_range(0, MAX_INDEX)), 1'b0,
                                  no_entry);
                    end else begin
                        send_word(OP_BUILD, IDX_W'($urandom_range(0, MAX_INDEX)), 1'b0,
                                  no_entry);
                    end
                    sent++;
                    if ($urandom_range(0, 29) == 0) drain_results();
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_points.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
